@@ design/gmpcd_pkg.sv @@
package gmpcd_pkg;

  // fixed field widths
  localparam int DATA_W = 32;
  localparam int KIND_W = 3;
  localparam int AW_W   = 6;

  // default port width and reset value of the width register
  localparam int DEF_MAX_WIDTH = 32;
  localparam logic [AW_W-1:0] RESET_WIDTH = 6'd17;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam logic REG_ACTIVE_WIDTH = 1'b0;

  // command kinds
  localparam logic [KIND_W-1:0] KIND_RESET     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SET_DIR   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_READ      = 3'd3;
  localparam logic [KIND_W-1:0] KIND_WATCH_RST = 3'd4;
  localparam logic [KIND_W-1:0] KIND_POLL      = 3'd5;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] pins;
  } in_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] port_view;
    logic [DATA_W-1:0] direction;
    logic [DATA_W-1:0] width_mask;
    logic [DATA_W-1:0] watch_value;
    logic [DATA_W-1:0] watch_mask;
    logic              changed;
  } out_res_t;

endpackage

@@ design/gmpcd_regs.sv @@
module gmpcd_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [gmpcd_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [gmpcd_pkg::DATA_W-1:0]      pwdata,
  output logic [gmpcd_pkg::DATA_W-1:0]      prdata,
  output logic                              pready,
  output logic [gmpcd_pkg::AW_W-1:0]        active_width
);

  logic [gmpcd_pkg::AW_W-1:0] active_width_r;
  logic                       sel_width;

  // word index is the top address bit, byte offset ignored
  assign sel_width = (paddr[gmpcd_pkg::CFG_ADDR_W-1] == gmpcd_pkg::REG_ACTIVE_WIDTH);

  // width register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_width_r <= gmpcd_pkg::RESET_WIDTH;
    end else if (psel && penable && pwrite && sel_width) begin
      active_width_r <= pwdata[gmpcd_pkg::AW_W-1:0];
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    if (sel_width) begin
      prdata = gmpcd_pkg::DATA_W'(active_width_r);
    end
  end

  assign pready       = 1'b1;
  assign active_width = active_width_r;

endmodule

@@ design/gmpcd_exec.sv @@
module gmpcd_exec #(
  parameter int MAX_WIDTH = gmpcd_pkg::DEF_MAX_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        go,
  input  gmpcd_pkg::in_req_t          req,
  input  logic [gmpcd_pkg::AW_W-1:0]  active_width,
  output gmpcd_pkg::out_res_t         res
);

  localparam int DW = gmpcd_pkg::DATA_W;
  localparam int AW_CMP = gmpcd_pkg::AW_W;

  // port state, only the bits that can ever be in use are stored
  logic [MAX_WIDTH-1:0] latch_r, latch_nxt;
  logic [MAX_WIDTH-1:0] dir_r, dir_nxt;
  logic [MAX_WIDTH-1:0] snap_val_r, snap_val_nxt;
  logic [MAX_WIDTH-1:0] snap_msk_r, snap_msk_nxt;

  logic [DW-1:0] wm;
  logic [DW-1:0] latch_w, dir_w, sval_w, smsk_w;
  logic [DW-1:0] latch_n, dir_n, sval_n, smsk_n;
  logic [DW-1:0] upd, view_cur, view_new, poll_v;
  logic          changed;

  // ones over the active width, saturated at the port width
  always_comb begin
    for (int i = 0; i < DW; i++) begin
      wm[i] = (AW_CMP'(i) < active_width) && (i < MAX_WIDTH);
    end
  end

  // widen state, direction bits above the port are locked
  assign latch_w = DW'(latch_r);
  assign dir_w   = ~DW'(~dir_r);
  assign sval_w  = DW'(snap_val_r);
  assign smsk_w  = DW'(snap_msk_r);

  assign view_cur = ((latch_w & ~dir_w) | (req.pins & dir_w)) & wm;
  assign poll_v   = view_cur & smsk_w;

  // command decode
  always_comb begin
    latch_n = latch_w;
    dir_n   = dir_w;
    sval_n  = sval_w;
    smsk_n  = smsk_w;
    changed = 1'b0;
    upd     = '0;
    case (req.kind)
      gmpcd_pkg::KIND_RESET: begin
        latch_n = '0;
        dir_n   = '1;
      end
      gmpcd_pkg::KIND_WRITE: begin
        upd     = req.mask & ~dir_w & wm;
        latch_n = (latch_w & ~upd) | (req.value & upd);
      end
      gmpcd_pkg::KIND_SET_DIR: begin
        upd   = req.mask & wm;
        dir_n = (dir_w & ~upd) | (req.value & upd);
      end
      gmpcd_pkg::KIND_WATCH_RST: begin
        smsk_n = ~dir_w & wm;
        sval_n = view_cur & ~dir_w & wm;
      end
      gmpcd_pkg::KIND_POLL: begin
        if (poll_v != sval_w) begin
          changed = 1'b1;
          smsk_n  = poll_v ^ sval_w;
          sval_n  = poll_v;
        end
      end
      default: begin
      end
    endcase
  end

  assign latch_nxt    = latch_n[MAX_WIDTH-1:0];
  assign dir_nxt      = dir_n[MAX_WIDTH-1:0];
  assign snap_val_nxt = sval_n[MAX_WIDTH-1:0];
  assign snap_msk_nxt = smsk_n[MAX_WIDTH-1:0];

  // view after the command
  assign view_new = ((latch_n & ~dir_n) | (req.pins & dir_n)) & wm;

  // state update when the request moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_r    <= '0;
      dir_r      <= '1;
      snap_val_r <= '0;
      snap_msk_r <= '0;
    end else if (go) begin
      latch_r    <= latch_nxt;
      dir_r      <= dir_nxt;
      snap_val_r <= snap_val_nxt;
      snap_msk_r <= snap_msk_nxt;
    end
  end

  always_comb begin
    res.port_view   = view_new;
    res.direction   = dir_n;
    res.width_mask  = wm;
    res.watch_value = sval_n;
    res.watch_mask  = smsk_n;
    res.changed     = changed;
  end

endmodule

@@ design/gpio_masked_port_change_detect.sv @@
// channel   | direction | handshake           | payload
// in        | input     | in_valid / in_stall  | in_data  (kind, value, mask, pins)
// out       | output    | out_valid / out_stall| out_data (port_view .. changed)
// cfg       | input     | psel/penable/pwrite  | paddr, pwdata, prdata
//
// one request per cycle sustained while out_stall is low; a result is valid once its
// request has passed the input register, then the result register
// port state is updated as a request moves from the input to the result register
// rst_n is synchronous: latch cleared, all bits locked, watcher cleared, width 17
// out_stall holds the result register and, once the input register is also
// full, raises in_stall in the same cycle
module gpio_masked_port_change_detect #(
  parameter int MAX_WIDTH = gmpcd_pkg::DEF_MAX_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  gmpcd_pkg::in_req_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output gmpcd_pkg::out_res_t               out_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [gmpcd_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [gmpcd_pkg::DATA_W-1:0]      pwdata,
  output logic [gmpcd_pkg::DATA_W-1:0]      prdata,
  output logic                              pready
);

  localparam logic [gmpcd_pkg::DATA_W-1:0] HI_LOCK =
    ~gmpcd_pkg::DATA_W'((64'd1 << MAX_WIDTH) - 64'd1);

  logic                       req_valid_r;
  gmpcd_pkg::in_req_t         req_r;
  logic                       out_valid_r;
  gmpcd_pkg::out_res_t        out_data_r;
  gmpcd_pkg::out_res_t        res;
  logic [gmpcd_pkg::AW_W-1:0] active_width;
  logic                       advance;
  logic                       in_take;

  gmpcd_regs u_regs (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .active_width (active_width)
  );

  gmpcd_exec #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_exec (
    .clk          (clk),
    .rst_n        (rst_n),
    .go           (advance),
    .req          (req_r),
    .active_width (active_width),
    .res          (res)
  );

  // handshake control
  assign advance  = req_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = req_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_take) begin
      req_valid_r <= 1'b1;
    end else if (advance) begin
      req_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      req_r <= in_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a flagged change always narrows to a nonempty set of bits
  a_changed_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.changed) |-> (out_data.watch_mask != '0))
    else $error("change flagged with empty watch mask");

  // bits beyond the port width stay locked
  a_hi_locked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.direction & HI_LOCK) == HI_LOCK))
    else $error("direction bit beyond port width unlocked");

  // a blocked request stays in the input register
  a_req_held: assert property (@(posedge clk) disable iff (!rst_n)
    (req_valid_r && !advance) |=> (req_valid_r && $stable(req_r)))
    else $error("blocked request lost");

  // width mask never exceeds the port
  a_wm_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.width_mask & HI_LOCK) == '0))
    else $error("width mask beyond port width");

endmodule

@@ tb/gpio_port_checker.sv @@
module gpio_port_checker
  import gmpcd_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter logic [CFG_ADDR_W-1:0] WIDTH_ADDR = '0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_req_t               in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_res_t              out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]     pwdata,
  input  logic                  pready,
  output int                    fail_count,
  output int                    results_owed
);

  // shadow copy of the port state
  logic [AW_W-1:0]   port_width;
  logic [DATA_W-1:0] drive_latch;
  logic [DATA_W-1:0] lock_bits;
  logic [DATA_W-1:0] watch_snap;
  logic [DATA_W-1:0] watch_bits;

  out_res_t owed_results[$];

  // ones over the active width, saturated at the port size
  function automatic logic [DATA_W-1:0] width_ones(input logic [AW_W-1:0] w);
    int n;
    n = (int'(w) > MAX_WIDTH) ? MAX_WIDTH : int'(w);
    if (n <= 0) return '0;
    if (n >= DATA_W) return '1;
    return (DATA_W'(1) << n) - DATA_W'(1);
  endfunction

  // latch on unlocked bits, pins on locked bits
  function automatic logic [DATA_W-1:0] port_seen(input logic [DATA_W-1:0] pins,
                                                  input logic [DATA_W-1:0] wm);
    return ((drive_latch & ~lock_bits) | (pins & lock_bits)) & wm;
  endfunction

  // apply one request to the shadow state and build the result it gives
  function automatic out_res_t step_port(input in_req_t r);
    logic [DATA_W-1:0] wm, m, v;
    out_res_t res;
    wm = width_ones(port_width);
    res.changed = 1'b0;
    case (r.kind)
      KIND_RESET: begin
        drive_latch = '0;
        lock_bits   = '1;
      end
      KIND_WRITE: begin
        m = r.mask & ~lock_bits & wm;
        drive_latch = (drive_latch & ~m) | (r.value & m);
      end
      KIND_SET_DIR: begin
        m = r.mask & wm;
        lock_bits = (lock_bits & ~m) | (r.value & m);
      end
      KIND_WATCH_RST: begin
        watch_bits = ~lock_bits & wm;
        watch_snap = port_seen(r.pins, wm) & watch_bits;
      end
      KIND_POLL: begin
        v = port_seen(r.pins, wm) & watch_bits;
        if (v != watch_snap) begin
          res.changed = 1'b1;
          watch_bits  = v ^ watch_snap;
          watch_snap  = v;
        end
      end
      default: ;
    endcase
    res.port_view   = port_seen(r.pins, wm);
    res.direction   = lock_bits;
    res.width_mask  = wm;
    res.watch_value = watch_snap;
    res.watch_mask  = watch_bits;
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [DATA_W-1:0] want,
                                      input logic [DATA_W-1:0] got);
    if (got !== want) begin
      $error("%s expected %h got %h", name, want, got);
      fail_count++;
    end
  endfunction

  // follow register writes, compare results, predict accepted requests
  always @(posedge clk) begin
    out_res_t want;
    if (!rst_n) begin
      port_width  = RESET_WIDTH;
      drive_latch = '0;
      lock_bits   = '1;
      watch_snap  = '0;
      watch_bits  = '0;
      fail_count  = 0;
      owed_results.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == WIDTH_ADDR) begin
        port_width = pwdata[AW_W-1:0];
      end
      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          $error("result with no request waiting: %p", out_data);
          fail_count++;
        end else begin
          want = owed_results.pop_front();
          check_field("port_view", want.port_view, out_data.port_view);
          check_field("direction", want.direction, out_data.direction);
          check_field("width_mask", want.width_mask, out_data.width_mask);
          check_field("watch_value", want.watch_value, out_data.watch_value);
          check_field("watch_mask", want.watch_mask, out_data.watch_mask);
          check_field("changed", DATA_W'(want.changed), DATA_W'(out_data.changed));
        end
      end
      if (in_valid && !in_stall) begin
        owed_results.push_back(step_port(in_data));
      end
    end
    results_owed = owed_results.size();
  end

endmodule

@@ tb/tb_top.sv @@
module tb_top;
  import gmpcd_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] WIDTH_ADDR = CFG_ADDR_W'(REG_ACTIVE_WIDTH) << 2;
  localparam logic [KIND_W-1:0] KIND_UNUSED_A = 3'd6;
  localparam logic [KIND_W-1:0] KIND_UNUSED_B = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_res_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  int fail_count;
  int results_owed;
  int burst_left = 0;
  logic [DATA_W-1:0] pin_levels = '0;

  // stall pattern state
  int stall_mode = 0;
  int stall_run = 0;

  gpio_masked_port_change_detect DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  gpio_port_checker #(.WIDTH_ADDR(WIDTH_ADDR)) checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver stall: free, light, heavy and periodic stretches
  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_run  <= $urandom_range(20, 200);
    end else begin
      stall_run <= stall_run - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (stall_run % 3 == 0);
    endcase
  end

  // one request, with a random gap at the start of each burst
  task automatic send_cmd(input logic [KIND_W-1:0] kind, input logic [DATA_W-1:0] value,
                          input logic [DATA_W-1:0] mask, input logic [DATA_W-1:0] pins);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= '{kind: kind, value: value, mask: mask, pins: pins};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // sender stops until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (results_owed != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // zero, all ones, a single bit or a random word
  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return DATA_W'(1) << $urandom_range(0, DATA_W - 1);
      default: return $urandom();
    endcase
  endfunction

  // mostly port traffic with slowly drifting pins, some noise
  task automatic send_random();
    int pick;
    logic [KIND_W-1:0] kind;
    pick = $urandom_range(0, 99);
    if (pick < 5) kind = KIND_RESET;
    else if (pick < 30) kind = KIND_WRITE;
    else if (pick < 45) kind = KIND_SET_DIR;
    else if (pick < 55) kind = KIND_READ;
    else if (pick < 67) kind = KIND_WATCH_RST;
    else if (pick < 95) kind = KIND_POLL;
    else kind = pick[0] ? KIND_UNUSED_A : KIND_UNUSED_B;
    case ($urandom_range(0, 7))
      0, 1: pin_levels = pin_levels ^ (DATA_W'(1) << $urandom_range(0, DATA_W - 1));
      2: pin_levels = $urandom();
      3: pin_levels = pick_word();
      default: ;
    endcase
    send_cmd(kind, pick_word(), pick_word(), pin_levels);
  endtask

  int widths[9] = '{32, 1, 0, 63, 33, 31, 8, 20, 17};

  // stimulus and verdict
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, every command, watcher corners
    send_cmd(KIND_READ, '0, '0, '1);
    send_cmd(KIND_READ, '1, '1, '0);
    send_cmd(KIND_WRITE, '1, '1, '1);                       // all locked, no effect
    send_cmd(KIND_SET_DIR, '0, '1, '0);                     // unlock bits in width
    send_cmd(KIND_WRITE, '1, '1, '0);
    send_cmd(KIND_WRITE, '0, 32'h5555_5555, '1);
    send_cmd(KIND_READ, '0, '0, 32'hA5A5_A5A5);
    send_cmd(KIND_WATCH_RST, '0, '0, '0);
    send_cmd(KIND_POLL, '1, '1, '1);                        // unlocked bits unchanged
    send_cmd(KIND_WRITE, 32'h0000_0001, 32'h0000_0001, '0);
    send_cmd(KIND_POLL, '0, '0, '0);                        // change, mask narrows
    send_cmd(KIND_POLL, '0, '0, '0);                        // same again, no change
    send_cmd(KIND_SET_DIR, 32'h0000_00F0, 32'h0000_00F0, '0);
    send_cmd(KIND_SET_DIR, '1, '0, '0);                     // empty mask
    send_cmd(KIND_WATCH_RST, '0, '0, 32'h0000_00F0);
    send_cmd(KIND_POLL, '0, '0, '1);                        // locked bits not watched
    send_cmd(KIND_UNUSED_A, '1, '1, '1);
    send_cmd(KIND_UNUSED_B, '0, '0, '0);
    send_cmd(KIND_RESET, '1, '1, '0);                       // watcher kept
    send_cmd(KIND_POLL, '0, '0, '1);                        // pins now seen by watch
    send_cmd(KIND_READ, 32'hFFFF_0000, 32'h0000_FFFF, 32'h8000_0001);

    // width phases with random traffic
    foreach (widths[i]) begin
      drain();
      cfg_write(WIDTH_ADDR, DATA_W'(widths[i]));
      @(posedge clk);
      send_cmd(KIND_SET_DIR, $urandom(), '1, pin_levels);
      repeat (82) send_random();
    end

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #(12 * 400000);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
